// ===== sv/tkl_pkg.sv =====
// Shared types and constants for the streaming top-k (largest) selector.
// Used by tkl_cell, streaming_top_k_largest_core and tkl_checker.
package tkl_pkg;

  localparam int CAPACITY    = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int KEEP_WIDTH  = 5;
  // count runs 0..CAPACITY
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [KEEP_WIDTH-1:0] KEEP_RESET = KEEP_WIDTH'(16);

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DRAIN  = 1'b1;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;

  typedef struct packed {
    logic   opcode;
    value_t sample_value;
  } in_item_t;

  typedef struct packed {
    value_t result_value;
    logic   result_valid;
    logic   result_last;
  } out_item_t;

  typedef struct packed {
    logic insert;  // an insert is taking place this cycle
    logic active;  // this cell lies within the part of the chain being rewritten
    logic occ;     // this cell holds a value
    logic shift;   // drain: take the value of the right neighbor
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DRAIN,
    S_EMPTY
  } state_t;

endpackage

// ===== sv/tkl_cell.sv =====
// One cell of the sorted chain: holds one value and its place in descending order.
// Depends on tkl_pkg for value_t and cell_ctrl_t.
module tkl_cell
  import tkl_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  value_t     sample,
  input  value_t     left_value,
  input  logic       left_ge,
  input  value_t     right_value,
  output value_t     value,
  output logic       ge
);

  // set when the new sample belongs at or before this cell
  assign ge = !ctrl.occ || (sample > value);

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      value <= right_value;
    end else if (ctrl.insert && ctrl.active && ge) begin
      // cells past the insert point move down by one
      value <= left_ge ? left_value : sample;
    end
  end

endmodule

// ===== sv/streaming_top_k_largest_core.sv =====
// Top level of the streaming top-k (largest) selector.
// Depends on tkl_pkg and tkl_cell.
//
// Keeps the keep_count largest signed values offered since the last drain in a
// chain of CAPACITY cells sorted in descending order. For an insert item, every
// cell compares the sample against its own value at once and the chain shifts
// down behind the insert point, so inserts are accepted every cycle while no
// drain is in progress, also while a result waits at the output. Once
// keep_count values are held, a sample replaces the smallest only when strictly
// greater. A drain item shifts the chain toward the output one value per cycle
// while the output is free, largest first, with result_last on the final one;
// it yields one result per held value, and in_ready stays low until its last
// result is in the output register. A drain of an empty store yields one result
// with result_valid low and result_last high. keep_count of 0 acts as 1, above
// CAPACITY as CAPACITY; lowering it discards nothing before the next drain.
module streaming_top_k_largest_core
  import tkl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [KEEP_WIDTH-1:0] cfg_wdata
);

  logic [KEEP_WIDTH-1:0] keep_count;
  logic [CW-1:0]         keep_eff;
  logic [CW-1:0]         count;
  logic [CW-1:0]         count_next;
  logic [CW-1:0]         count_m1;
  state_t                state;
  state_t                state_next;

  value_t                cell_value [CAPACITY];
  logic [CAPACITY-1:0]   cell_ge;
  cell_ctrl_t            cell_ctrl [CAPACITY];

  logic                  in_fire;
  logic                  grow;
  logic                  do_insert;
  logic                  do_shift;
  logic                  out_free;
  logic                  out_load;
  out_item_t             out_data_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_count <= KEEP_RESET;
    end else if (cfg_we) begin
      keep_count <= cfg_wdata;
    end
  end

  always_comb begin
    if (keep_count == '0) begin
      keep_eff = CW'(1);
    end else if (int'(keep_count) > CAPACITY) begin
      keep_eff = CW'(CAPACITY);
    end else begin
      keep_eff = CW'(keep_count);
    end
  end

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign grow     = (count < keep_eff);
  assign count_m1 = count - CW'(1);
  assign out_free = !out_valid || out_ready;

  // in replace mode only held cells are active, and a sample no greater than
  // the smallest held value finds no cell with ge set, so the chain holds
  assign do_insert = in_fire && (in_data.opcode == OP_INSERT);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    value_t left_value;
    logic   left_ge;
    value_t right_value;

    always_comb begin
      cell_ctrl[i].insert = do_insert;
      cell_ctrl[i].occ    = (CW'(i) < count);
      cell_ctrl[i].active = (CW'(i) < count) || (grow && (CW'(i) == count));
      cell_ctrl[i].shift  = do_shift;
    end

    if (i == 0) begin : g_head
      assign left_value = '0;
      assign left_ge    = 1'b0;
    end else begin : g_body
      assign left_value = cell_value[i-1];
      assign left_ge    = cell_ge[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_value = '0;
    end else begin : g_inner
      assign right_value = cell_value[i+1];
    end

    tkl_cell u_cell (
      .clk         (clk),
      .ctrl        (cell_ctrl[i]),
      .sample      (in_data.sample_value),
      .left_value  (left_value),
      .left_ge     (left_ge),
      .right_value (right_value),
      .value       (cell_value[i]),
      .ge          (cell_ge[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_comb begin
    state_next    = state;
    count_next    = count;
    do_shift      = 1'b0;
    out_load      = 1'b0;
    out_data_next = '{result_value: '0, result_valid: 1'b0, result_last: 1'b1};
    case (state)
      S_IDLE: begin
        if (in_fire && (in_data.opcode == OP_DRAIN)) begin
          state_next = (count == '0) ? S_EMPTY : S_DRAIN;
        end else if (do_insert && grow) begin
          count_next = count + CW'(1);
        end
      end
      S_DRAIN: begin
        if (out_free) begin
          // emit the head and advance the chain
          out_load      = 1'b1;
          do_shift      = 1'b1;
          out_data_next = '{result_value: cell_value[0], result_valid: 1'b1,
                            result_last: (count == CW'(1))};
          count_next    = count_m1;
          if (count == CW'(1)) begin
            state_next = S_IDLE;
          end
        end
      end
      S_EMPTY: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= out_data_next;
    end
  end

endmodule

// ===== sv/tkl_checker.sv =====
// Port-level checks for the streaming top-k selector, bound to its top level.
// Depends on tkl_pkg for the item types.
module tkl_checker
  import tkl_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input in_item_t              in_data,
  input logic                  out_valid,
  input logic                  out_ready,
  input out_item_t             out_data
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown right after reset");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.result_valid |-> out_data.result_last)
    else $error("empty drain result without last");

  // a drain in progress blocks new items until its last result is out
  a_drain_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.result_last |-> !in_ready)
    else $error("item accepted in the middle of a drain");

endmodule

bind streaming_top_k_largest_core tkl_checker u_tkl_checker (.*);
